[src/mbea_pkg.sv]
// types, register indexes, result codes and reset values for the mouse edge and accel unit
package mbea_pkg;

  localparam int unsigned LANES    = 2;
  localparam int unsigned MAG_W    = 8;
  localparam int unsigned PROD_W   = 15;
  localparam int unsigned MUL_STEPS = 8;
  localparam int unsigned DIV_STEPS = PROD_W;

  localparam logic [1:0] REG_THRESHOLD   = 2'd0;
  localparam logic [1:0] REG_NUMERATOR   = 2'd1;
  localparam logic [1:0] REG_DENOMINATOR = 2'd2;

  localparam logic [6:0] THRESHOLD_RESET   = 7'd4;
  localparam logic [7:0] NUMERATOR_RESET   = 8'd2;
  localparam logic [7:0] DENOMINATOR_RESET = 8'd1;

  localparam logic [1:0] KIND_PRESS   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_MOTION  = 2'd2;

  localparam logic [1:0] BUTTON_NONE = 2'd0;

  typedef struct packed {
    logic [2:0]        button_mask;
    logic signed [7:0] raw_dx;
    logic signed [7:0] raw_dy;
    logic [31:0]       event_time;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         event_kind;
    logic [1:0]         button_number;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic [31:0]        stamp;
    logic               last_of_run;
  } out_word_t;

endpackage

[src/mouse_button_edge_and_accel_unit.sv]
// top level: button edge results and serial threshold acceleration of mouse motion
// motion path: a report's motion result is computed and loaded in these steps
//   (8 bit-serial multiply steps, 15 restoring divide steps, 1 output load)
// a new report waits until the last motion result is loaded; each axis has its own serial
//   multiply and divide; button results leave meanwhile, one button per unstalled cycle
// reset: threshold 4, numerator 2, denominator 1, all buttons released, no result pending
module mouse_button_edge_and_accel_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mbea_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output mbea_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_BTN, S_MOT} state_t;
  typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV} arith_t;

  state_t state;
  arith_t arith;

  logic [6:0]  thr;
  logic [7:0]  num;
  logic [7:0]  den;
  logic [2:0]  prev_buttons;
  logic [2:0]  mask;
  logic [2:0]  change;
  logic [1:0]  bidx;
  logic [31:0] stamp;
  logic [3:0]  cnt;
  logic        a_done;

  logic                            neg    [mbea_pkg::LANES];
  logic                            accel  [mbea_pkg::LANES];
  logic [mbea_pkg::MAG_W-1:0]      mag    [mbea_pkg::LANES];
  logic [mbea_pkg::PROD_W-1:0]     mcand  [mbea_pkg::LANES];
  logic [7:0]                      mplier [mbea_pkg::LANES];
  logic [mbea_pkg::PROD_W-1:0]     acc    [mbea_pkg::LANES];
  logic [7:0]                      rem    [mbea_pkg::LANES];

  logic [7:0]  raw_in  [mbea_pkg::LANES];
  logic [7:0]  mag_in  [mbea_pkg::LANES];
  logic [8:0]  trial   [mbea_pkg::LANES];
  logic        dgt     [mbea_pkg::LANES];
  logic [15:0] mag_out [mbea_pkg::LANES];
  logic [15:0] res     [mbea_pkg::LANES];

  logic [7:0]  den_eff;
  logic        accept;
  logic        slot_free;
  logic        load_out;
  logic [2:0]  new_change;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign slot_free = !out_valid || !out_stall;
  assign load_out  = slot_free && ((state == S_BTN && change[bidx]) ||
                                   (state == S_MOT && a_done));
  assign den_eff   = (den == 8'd0) ? 8'd1 : den;
  assign new_change = in_word.button_mask ^ prev_buttons;

  assign raw_in[0] = in_word.raw_dx;
  assign raw_in[1] = in_word.raw_dy;

  always_comb begin
    for (int l = 0; l < mbea_pkg::LANES; l++) begin
      mag_in[l]  = raw_in[l][7] ? 8'(~raw_in[l] + 8'd1) : raw_in[l];
      trial[l]   = {rem[l], acc[l][mbea_pkg::PROD_W-1]};
      dgt[l]     = (trial[l] >= {1'b0, den_eff});
      mag_out[l] = accel[l] ? (16'(thr) + {1'b0, acc[l]}) : {8'd0, mag[l]};
      res[l]     = neg[l] ? 16'(~mag_out[l] + 16'd1) : mag_out[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      arith        <= A_IDLE;
      thr          <= mbea_pkg::THRESHOLD_RESET;
      num          <= mbea_pkg::NUMERATOR_RESET;
      den          <= mbea_pkg::DENOMINATOR_RESET;
      prev_buttons <= 3'd0;
      out_valid    <= 1'b0;
      a_done       <= 1'b0;
      cnt          <= 4'd0;
      bidx         <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          mbea_pkg::REG_THRESHOLD:   thr <= cfg_data[6:0];
          mbea_pkg::REG_NUMERATOR:   num <= cfg_data;
          mbea_pkg::REG_DENOMINATOR: den <= cfg_data;
          default: ;
        endcase
      end

      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      // serial arithmetic, both axes side by side
      unique case (arith)
        A_IDLE: begin
          if (accept) begin
            arith  <= A_MUL;
            cnt    <= 4'd0;
            a_done <= 1'b0;
            for (int l = 0; l < mbea_pkg::LANES; l++) begin
              neg[l]    <= raw_in[l][7];
              mag[l]    <= mag_in[l];
              accel[l]  <= (mag_in[l] > {1'b0, thr});
              mcand[l]  <= {7'd0, 8'(mag_in[l] - {1'b0, thr})};
              mplier[l] <= num;
              acc[l]    <= '0;
            end
          end
        end
        A_MUL: begin
          for (int l = 0; l < mbea_pkg::LANES; l++) begin
            if (mplier[l][0]) acc[l] <= acc[l] + mcand[l];
            mcand[l]  <= {mcand[l][mbea_pkg::PROD_W-2:0], 1'b0};
            mplier[l] <= {1'b0, mplier[l][7:1]};
          end
          if (cnt == 4'(mbea_pkg::MUL_STEPS - 1)) begin
            arith <= A_DIV;
            cnt   <= 4'd0;
            for (int l = 0; l < mbea_pkg::LANES; l++) rem[l] <= 8'd0;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        A_DIV: begin
          for (int l = 0; l < mbea_pkg::LANES; l++) begin
            rem[l] <= dgt[l] ? 8'(trial[l] - {1'b0, den_eff}) : trial[l][7:0];
            acc[l] <= {acc[l][mbea_pkg::PROD_W-2:0], dgt[l]};
          end
          if (cnt == 4'(mbea_pkg::DIV_STEPS - 1)) begin
            arith  <= A_IDLE;
            a_done <= 1'b1;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        default: arith <= A_IDLE;
      endcase

      // result sequencing
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            mask         <= in_word.button_mask;
            change       <= new_change;
            stamp        <= in_word.event_time;
            prev_buttons <= in_word.button_mask;
            bidx         <= 2'd0;
            state        <= (new_change != 3'd0) ? S_BTN : S_MOT;
          end
        end
        S_BTN: begin
          if (slot_free) begin
            if (change[bidx]) begin
              out_word.event_kind    <= mask[bidx] ? mbea_pkg::KIND_PRESS
                                                   : mbea_pkg::KIND_RELEASE;
              out_word.button_number <= bidx + 2'd1;
              out_word.move_x        <= '0;
              out_word.move_y        <= '0;
              out_word.stamp         <= stamp;
              out_word.last_of_run   <= 1'b0;
            end
            bidx <= bidx + 2'd1;
            if (bidx == 2'd2) state <= S_MOT;
          end
        end
        S_MOT: begin
          if (slot_free && a_done) begin
            out_word.event_kind    <= mbea_pkg::KIND_MOTION;
            out_word.button_number <= mbea_pkg::BUTTON_NONE;
            out_word.move_x        <= res[0];
            out_word.move_y        <= res[1];
            out_word.stamp         <= stamp;
            out_word.last_of_run   <= 1'b1;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/mbea_checker.sv]
// port-level checker for the mouse edge and accel unit, bound to the top level
module mbea_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input mbea_pkg::out_word_t out_word,
  input logic                cfg_ready
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // one report at a time: an accepted word closes the input
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after accept");

  // motion results close the run and carry no button
  a_motion_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.event_kind == mbea_pkg::KIND_MOTION |->
      out_word.last_of_run && out_word.button_number == mbea_pkg::BUTTON_NONE)
    else $error("bad motion result fields");

  // button results carry no motion and do not close the run
  a_button_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.event_kind != mbea_pkg::KIND_MOTION |->
      !out_word.last_of_run && out_word.move_x == 16'sd0 && out_word.move_y == 16'sd0
      && out_word.button_number != mbea_pkg::BUTTON_NONE)
    else $error("bad button result fields");

  // configuration only opens while the input side is open
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !in_stall)
    else $error("config open while busy");

endmodule

bind mouse_button_edge_and_accel_unit mbea_checker u_mbea_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word),
  .cfg_ready (cfg_ready)
);

[test/tb_top.sv]
// self-checking bench for the mouse button edge and motion acceleration unit
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] BUTTON_LEFT   = 2'd1;
  localparam logic [1:0] BUTTON_MIDDLE = 2'd2;
  localparam logic [1:0] BUTTON_RIGHT  = 2'd3;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_AT       = 150;
  localparam int HOLD_CYCLES   = 400;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  mbea_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  mbea_pkg::out_word_t out_word;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [7:0]          cfg_data = '0;

  mouse_button_edge_and_accel_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [6:0] model_threshold = mbea_pkg::THRESHOLD_RESET;
  logic [7:0] model_numer     = mbea_pkg::NUMERATOR_RESET;
  logic [7:0] model_denom     = mbea_pkg::DENOMINATOR_RESET;
  logic [2:0] model_buttons   = 3'b000;

  mbea_pkg::in_word_t  pending_reports[$];
  mbea_pkg::out_word_t expected_events[$];

  int reports_queued = 0;
  int reports_taken  = 0;
  int events_checked = 0;
  int button_edges   = 0;
  int reg_writes     = 0;
  int error_count    = 0;
  int cycle_count    = 0;

  logic       in_fire = 1'b0;
  int         burst_left = 1;
  int         gap_left = 0;
  int         stall_mode = 0;
  int         mode_left = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;

  logic [2:0]  gen_mask = 3'b000;
  logic [31:0] gen_clock_ms = 32'd0;

  function automatic logic signed [15:0] accel_axis(logic signed [7:0] raw);
    int mag;
    int thr;
    int den;
    int res;
    mag = (raw < 0) ? -int'(raw) : int'(raw);
    thr = int'(model_threshold);
    den = (model_denom == 8'd0) ? 1 : int'(model_denom);
    res = mag;
    if (mag > thr) res = thr + ((mag - thr) * int'(model_numer)) / den;
    return (raw < 0) ? 16'(-res) : 16'(res);
  endfunction

  task automatic predict_report(mbea_pkg::in_word_t w);
    mbea_pkg::out_word_t e;
    for (int i = 0; i < 3; i++) begin
      if (w.button_mask[i] != model_buttons[i]) begin
        e = '0;
        e.event_kind = w.button_mask[i] ? mbea_pkg::KIND_PRESS : mbea_pkg::KIND_RELEASE;
        case (i)
          0: e.button_number = BUTTON_LEFT;
          1: e.button_number = BUTTON_MIDDLE;
          default: e.button_number = BUTTON_RIGHT;
        endcase
        e.stamp = w.event_time;
        expected_events.push_back(e);
        button_edges++;
      end
    end
    model_buttons = w.button_mask;
    e = '0;
    e.event_kind    = mbea_pkg::KIND_MOTION;
    e.button_number = mbea_pkg::BUTTON_NONE;
    e.move_x        = accel_axis(w.raw_dx);
    e.move_y        = accel_axis(w.raw_dy);
    e.stamp         = w.event_time;
    e.last_of_run   = 1'b1;
    expected_events.push_back(e);
  endtask

  task automatic check_event(mbea_pkg::out_word_t got);
    mbea_pkg::out_word_t want;
    if (expected_events.size() == 0) begin
      $error("result word with nothing expected: kind %0d button %0d stamp %0h",
             got.event_kind, got.button_number, got.stamp);
      error_count++;
    end else begin
      want = expected_events.pop_front();
      events_checked++;
      if (got.event_kind !== want.event_kind) begin
        $error("event_kind expected %0d actual %0d", want.event_kind, got.event_kind);
        error_count++;
      end
      if (got.button_number !== want.button_number) begin
        $error("button_number expected %0d actual %0d", want.button_number,
               got.button_number);
        error_count++;
      end
      if (got.move_x !== want.move_x) begin
        $error("move_x expected %0d actual %0d", want.move_x, got.move_x);
        error_count++;
      end
      if (got.move_y !== want.move_y) begin
        $error("move_y expected %0d actual %0d", want.move_y, got.move_y);
        error_count++;
      end
      if (got.stamp !== want.stamp) begin
        $error("stamp expected %0h actual %0h", want.stamp, got.stamp);
        error_count++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run expected %0b actual %0b", want.last_of_run, got.last_of_run);
        error_count++;
      end
    end
  endtask

  // monitor: accepted words on both channels, plus the run limit
  always @(posedge clk) begin
    cycle_count++;
    if (!rst && in_valid && !in_stall) begin
      predict_report(in_word);
      reports_taken++;
      in_fire = 1'b1;
    end else begin
      in_fire = 1'b0;
    end
    if (!rst && out_valid && !out_stall) check_event(out_word);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // driver: bursts of words with random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // stalled word holds
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (pending_reports.size() > 0) begin
      in_word  <= pending_reports.pop_front();
      in_valid <= 1'b1;
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 8);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver stall pattern, with one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (!hold_done && reports_taken >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) == 0);
          2: out_stall <= ($urandom_range(0, 7) == 0);
          default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic add_report(logic [2:0] mask, logic [7:0] dx, logic [7:0] dy,
                            logic [31:0] stamp);
    mbea_pkg::in_word_t w;
    w.button_mask = mask;
    w.raw_dx      = dx;
    w.raw_dy      = dy;
    w.event_time  = stamp;
    pending_reports.push_back(w);
    reports_queued++;
  endtask

  function automatic logic [7:0] rand_axis();
    int m;
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'($urandom);
      3, 4, 5: begin
        m = int'(model_threshold) + int'($urandom_range(0, 2)) - 1;
        if (m < 0) m = 0;
        if ($urandom_range(0, 1) == 1) begin
          if (m > 128) m = 128;
          return 8'(-m);
        end
        if (m > 127) m = 127;
        return 8'(m);
      end
      default: return 8'(int'($urandom_range(0, 20)) - 10);
    endcase
  endfunction

  task automatic add_random_reports(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 2) != 0) gen_mask = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 9) == 0) gen_clock_ms = $urandom;
      else gen_clock_ms = gen_clock_ms + $urandom_range(0, 1000);
      add_report(gen_mask, rand_axis(), rand_axis(), gen_clock_ms);
    end
  endtask

  task automatic wait_idle();
    while (reports_taken != reports_queued || expected_events.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      mbea_pkg::REG_THRESHOLD:   model_threshold = data[6:0];
      mbea_pkg::REG_NUMERATOR:   model_numer     = data;
      mbea_pkg::REG_DENOMINATOR: model_denom     = data;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic [7:0] thr, logic [7:0] num, logic [7:0] den, int count);
    wait_idle();
    write_reg(mbea_pkg::REG_THRESHOLD, thr);
    write_reg(mbea_pkg::REG_NUMERATOR, num);
    write_reg(mbea_pkg::REG_DENOMINATOR, den);
    add_random_reports(count);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed words under reset settings
    add_report(3'b000, 8'd0,    8'd0,    32'h0000_0000);
    add_report(3'b001, 8'd4,    8'hFC,   32'h0000_0001);
    add_report(3'b011, 8'd5,    8'hFB,   32'h0000_0002);
    add_report(3'b111, 8'h7F,   8'h80,   32'hFFFF_FFFF);
    add_report(3'b111, 8'h80,   8'h7F,   32'hFFFF_FFFE);
    add_report(3'b110, 8'hFF,   8'd1,    32'h5555_5555);
    add_report(3'b100, 8'h55,   8'hAA,   32'hAAAA_AAAA);
    add_report(3'b000, 8'hAA,   8'h55,   32'h0000_0010);
    add_report(3'b111, 8'd3,    8'hFD,   32'h0000_0011);
    add_report(3'b000, 8'd6,    8'hFA,   32'h0000_0012);
    add_report(3'b101, 8'd0,    8'h80,   32'h0000_0013);
    add_report(3'b010, 8'h80,   8'd0,    32'h0000_0014);
    add_report(3'b010, 8'h7F,   8'h7F,   32'h0000_0015);
    add_report(3'b000, 8'h80,   8'h80,   32'h8000_0000);
    add_report(3'b100, 8'd1,    8'hFF,   32'h7FFF_FFFF);
    add_report(3'b001, 8'h40,   8'hC0,   32'h0000_0100);
    add_report(3'b000, 8'd0,    8'd0,    32'h0000_0101);
    gen_mask     = 3'b000;
    gen_clock_ms = 32'h0000_0200;

    run_phase(8'd0,   8'd255, 8'd1,   60);
    run_phase(8'd127, 8'd1,   8'd255, 60);
    run_phase(8'd0,   8'd0,   8'd0,   55);  // dropped excess and zero divisor
    run_phase(8'h85,  8'd3,   8'd2,   55);
    run_phase(8'($urandom), 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), 60);
    run_phase(8'd4,   8'd2,   8'd1,   60);

    wait_idle();
    $display("covered %0d reports and %0d register writes over seven settings",
             reports_taken, reg_writes);
    $display("checked %0d result words, %0d of them button edges",
             events_checked, button_edges);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[mouse_button_edge_and_accel_unit.f]
src/mbea_pkg.sv
src/mouse_button_edge_and_accel_unit.sv
src/mbea_checker.sv
test/tb_top.sv
